/* sv/touch_frame_tx_queue_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the touch frame transmit queue
// Shared shorthand for clocked assertions, reset-qualified on rst.
// ----------------------------------------------------------------------------
`ifndef TOUCH_FRAME_TX_QUEUE_CORE_MACROS_SVH
`define TOUCH_FRAME_TX_QUEUE_CORE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TFTQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// When cond holds, prop must hold in the following cycle.
`define TFTQ_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) cond |=> prop) else $error(msg);

`endif

/* sv/tftq_pkg.sv */
// ----------------------------------------------------------------------------
// Touch frame transmit queue package
// Queue sizing, frame and word types, status codes and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tftq_pkg;

  // Queue sizing.
  localparam int QUEUE_DEPTH = 8;
  localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

  // Reset value of the release attempt limit.
  localparam logic [3:0] LIMIT_RESET = 4'd4;

  // One stored frame.
  typedef struct packed {
    logic [7:0]  pad;
    logic [7:0]  contact;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  pressure;
    logic [7:0]  flags;
    logic [7:0]  seq;
    logic [15:0] stamp;
  } frame_t;

  localparam int FRAME_W = $bits(frame_t);

  // Input word.
  typedef struct packed {
    logic        mode;
    logic [7:0]  pad_id;
    logic [7:0]  contact_num;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  pressure;
    logic [7:0]  frame_flags;
    logic [7:0]  sequence_req;
    logic [15:0] stamp;
    logic        delivered;
  } in_t;

  // Result word.
  typedef struct packed {
    logic [2:0]  status;
    logic        head_valid;
    logic [7:0]  head_pad;
    logic [7:0]  head_contact;
    logic [15:0] head_x;
    logic [15:0] head_y;
    logic [7:0]  head_pressure;
    logic [7:0]  head_flags;
    logic [7:0]  head_sequence;
    logic [15:0] head_stamp;
    logic [3:0]  queue_fill;
  } out_t;

  // Input modes.
  localparam logic MODE_PUSH    = 1'b0;
  localparam logic MODE_OUTCOME = 1'b1;

  // Result status codes.
  localparam logic [2:0] STAT_QUEUED  = 3'd0;
  localparam logic [2:0] STAT_EVICTED = 3'd1;
  localparam logic [2:0] STAT_DROPPED = 3'd2;
  localparam logic [2:0] STAT_SENT    = 3'd3;
  localparam logic [2:0] STAT_RETRY   = 3'd4;
  localparam logic [2:0] STAT_FAILED  = 3'd5;
  localparam logic [2:0] STAT_EMPTY   = 3'd6;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_MOVE_CHK,
    S_MOVE_RD,
    S_MOVE_WR,
    S_TAIL_WR,
    S_OUT_RD,
    S_OUT_CHK,
    S_HEAD_RD,
    S_DONE
  } state_t;

  // Physical slot of the entry at a given offset behind the head.
  function automatic logic [SLOT_W-1:0] slot_at(input logic [SLOT_W-1:0] head,
                                                input logic [SLOT_W-1:0] offset);
    logic [SLOT_W:0] sum;
    sum = {1'b0, head} + {1'b0, offset};
    if (sum >= (SLOT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (SLOT_W+1)'(QUEUE_DEPTH);
    end
    return sum[SLOT_W-1:0];
  endfunction

  // Frame as it comes from a push word.
  function automatic frame_t frame_of(input in_t w);
    frame_t f;
    f.pad      = w.pad_id;
    f.contact  = w.contact_num;
    f.x        = w.pos_x;
    f.y        = w.pos_y;
    f.pressure = w.pressure;
    f.flags    = w.frame_flags;
    f.seq      = w.sequence_req;
    f.stamp    = w.stamp;
    return f;
  endfunction

endpackage

/* sv/tftq_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tftq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/touch_frame_tx_queue_core.sv */
// ----------------------------------------------------------------------------
// Touch frame transmit queue
// Ring queue of touch report frames with motion-frame eviction and retry.
// ----------------------------------------------------------------------------
// Each word is handled alone by a small sequencer around one frame RAM with a
// registered read port and one slot address adder, so the work per word is
// set by RAM accesses. A push into a queue with room writes the tail slot and
// reads the head; an outcome word reads and checks the head unless it is
// delivered or the queue is empty, then reads the new head. A push into a
// full queue first scans the entries behind the head, a read and a check
// each, until it finds a motion frame, then closes the gap with a read and
// a write per moved entry. The result sits in an output register, and a new
// word is taken as soon as the sequencer is back in idle. The frame RAM needs
// no clearing after reset, and the release attempt limit is taken only while the sequencer is idle.
`timescale 1ns / 1ps

module touch_frame_tx_queue_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tftq_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output tftq_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [3:0]      cfg_data
);

  `include "touch_frame_tx_queue_core_macros.svh"

  tftq_pkg::state_t                 state;
  tftq_pkg::state_t                 state_next;
  tftq_pkg::in_t                    item;
  logic [tftq_pkg::SLOT_W-1:0]      head_slot;
  logic [tftq_pkg::FILL_W-1:0]      fill_count;
  logic [3:0]                       attempts_spent;
  logic [3:0]                       attempt_limit;
  logic [tftq_pkg::SLOT_W-1:0]      idx;
  logic [2:0]                       status;

  logic                             in_fire;
  logic                             out_free;
  logic                             full;
  logic                             more_after;
  logic                             retry_ok;
  logic [tftq_pkg::FILL_W-1:0]      idx_inc;
  logic [tftq_pkg::SLOT_W-1:0]      offset;
  logic [tftq_pkg::SLOT_W-1:0]      slot;
  tftq_pkg::frame_t                 rd_frame;

  logic                             ram_we;
  logic                             ram_re;
  logic [tftq_pkg::FRAME_W-1:0]     ram_wdata;
  logic [tftq_pkg::FRAME_W-1:0]     ram_rdata;

  assign in_ready  = (state == tftq_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign cfg_ready = (state == tftq_pkg::S_IDLE);

  // Queue status terms used by the sequencer.
  assign full       = (fill_count == tftq_pkg::FILL_W'(tftq_pkg::QUEUE_DEPTH));
  assign idx_inc    = tftq_pkg::FILL_W'(idx) + tftq_pkg::FILL_W'(1);
  assign more_after = (idx_inc < fill_count);
  assign rd_frame   = tftq_pkg::frame_t'(ram_rdata);
  assign retry_ok   = !rd_frame.flags[0] &&
                      (({1'b0, attempts_spent} + 5'd1) < {1'b0, attempt_limit});

  // Frame storage.
  tftq_ram #(
    .WIDTH (tftq_pkg::FRAME_W),
    .DEPTH (tftq_pkg::QUEUE_DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      tftq_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_data.mode == tftq_pkg::MODE_PUSH) begin
            state_next = full ? tftq_pkg::S_SCAN_RD : tftq_pkg::S_TAIL_WR;
          end else if (fill_count == '0 || in_data.delivered) begin
            state_next = tftq_pkg::S_HEAD_RD;
          end else begin
            state_next = tftq_pkg::S_OUT_RD;
          end
        end
      end
      tftq_pkg::S_SCAN_RD: state_next = tftq_pkg::S_SCAN_CHK;
      tftq_pkg::S_SCAN_CHK: begin
        if (rd_frame.flags[0]) begin
          state_next = tftq_pkg::S_MOVE_CHK;
        end else if (more_after) begin
          state_next = tftq_pkg::S_SCAN_RD;
        end else begin
          state_next = tftq_pkg::S_HEAD_RD;
        end
      end
      tftq_pkg::S_MOVE_CHK: begin
        state_next = more_after ? tftq_pkg::S_MOVE_RD : tftq_pkg::S_TAIL_WR;
      end
      tftq_pkg::S_MOVE_RD: state_next = tftq_pkg::S_MOVE_WR;
      tftq_pkg::S_MOVE_WR: state_next = tftq_pkg::S_MOVE_CHK;
      tftq_pkg::S_TAIL_WR: state_next = tftq_pkg::S_HEAD_RD;
      tftq_pkg::S_OUT_RD:  state_next = tftq_pkg::S_OUT_CHK;
      tftq_pkg::S_OUT_CHK: state_next = tftq_pkg::S_HEAD_RD;
      tftq_pkg::S_HEAD_RD: state_next = tftq_pkg::S_DONE;
      tftq_pkg::S_DONE: begin
        if (out_free) begin
          state_next = tftq_pkg::S_IDLE;
        end
      end
      default: state_next = tftq_pkg::S_IDLE;
    endcase
  end

  // RAM controls and the offset fed to the shared slot adder.
  always_comb begin
    offset    = tftq_pkg::SLOT_W'(1);
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_wdata = tftq_pkg::frame_of(item);
    unique case (state)
      tftq_pkg::S_SCAN_RD: begin
        offset = idx;
        ram_re = 1'b1;
      end
      tftq_pkg::S_MOVE_RD: begin
        offset = idx_inc[tftq_pkg::SLOT_W-1:0];
        ram_re = 1'b1;
      end
      tftq_pkg::S_MOVE_WR: begin
        offset    = idx;
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      tftq_pkg::S_TAIL_WR: begin
        offset = fill_count[tftq_pkg::SLOT_W-1:0];
        ram_we = 1'b1;
      end
      tftq_pkg::S_OUT_RD, tftq_pkg::S_HEAD_RD: begin
        offset = '0;
        ram_re = 1'b1;
      end
      default: begin
        offset = tftq_pkg::SLOT_W'(1);
      end
    endcase
  end

  assign slot = tftq_pkg::slot_at(head_slot, offset);

  // Control state: sequencer, queue pointers, attempt count and limit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= tftq_pkg::S_IDLE;
      head_slot      <= '0;
      fill_count     <= '0;
      attempts_spent <= '0;
      attempt_limit  <= tftq_pkg::LIMIT_RESET;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        attempt_limit <= cfg_data;
      end
      // The result word appears when a word finishes and leaves once taken.
      if (state == tftq_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        tftq_pkg::S_IDLE: begin
          // A delivered head leaves at once.
          if (in_fire && in_data.mode == tftq_pkg::MODE_OUTCOME &&
              fill_count != '0 && in_data.delivered) begin
            head_slot      <= slot;
            fill_count     <= fill_count - tftq_pkg::FILL_W'(1);
            attempts_spent <= '0;
          end
        end
        tftq_pkg::S_MOVE_CHK: begin
          if (!more_after) begin
            fill_count <= fill_count - tftq_pkg::FILL_W'(1);
          end
        end
        tftq_pkg::S_TAIL_WR: begin
          fill_count <= fill_count + tftq_pkg::FILL_W'(1);
        end
        tftq_pkg::S_OUT_CHK: begin
          if (retry_ok) begin
            attempts_spent <= attempts_spent + 4'd1;
          end else begin
            head_slot      <= slot;
            fill_count     <= fill_count - tftq_pkg::FILL_W'(1);
            attempts_spent <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers: captured word, scan index, status and result.
  always_ff @(posedge clk) begin
    unique case (state)
      tftq_pkg::S_IDLE: begin
        if (in_fire) begin
          item <= in_data;
          idx  <= tftq_pkg::SLOT_W'(1);
          if (in_data.mode == tftq_pkg::MODE_PUSH) begin
            status <= tftq_pkg::STAT_QUEUED;
          end else if (fill_count == '0) begin
            status <= tftq_pkg::STAT_EMPTY;
          end else begin
            status <= tftq_pkg::STAT_SENT;
          end
        end
      end
      tftq_pkg::S_SCAN_CHK: begin
        if (rd_frame.flags[0]) begin
          status <= tftq_pkg::STAT_EVICTED;
        end else if (more_after) begin
          idx <= idx_inc[tftq_pkg::SLOT_W-1:0];
        end else begin
          status <= tftq_pkg::STAT_DROPPED;
        end
      end
      tftq_pkg::S_MOVE_WR: begin
        idx <= idx_inc[tftq_pkg::SLOT_W-1:0];
      end
      tftq_pkg::S_OUT_CHK: begin
        status <= retry_ok ? tftq_pkg::STAT_RETRY : tftq_pkg::STAT_FAILED;
      end
      tftq_pkg::S_DONE: begin
        if (out_free) begin
          out_data.status     <= status;
          out_data.head_valid <= (fill_count != '0);
          out_data.queue_fill <= 4'(fill_count);
          if (fill_count != '0) begin
            out_data.head_pad      <= rd_frame.pad;
            out_data.head_contact  <= rd_frame.contact;
            out_data.head_x        <= rd_frame.x;
            out_data.head_y        <= rd_frame.y;
            out_data.head_pressure <= rd_frame.pressure;
            out_data.head_flags    <= rd_frame.flags;
            out_data.head_sequence <= rd_frame.seq;
            out_data.head_stamp    <= rd_frame.stamp;
          end else begin
            out_data.head_pad      <= '0;
            out_data.head_contact  <= '0;
            out_data.head_x        <= '0;
            out_data.head_y        <= '0;
            out_data.head_pressure <= '0;
            out_data.head_flags    <= '0;
            out_data.head_sequence <= '0;
            out_data.head_stamp    <= '0;
          end
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

  // Checks on queue bookkeeping.
  `TFTQ_ASSERT(a_fill_bound, (fill_count <= tftq_pkg::FILL_W'(tftq_pkg::QUEUE_DEPTH)), "fill exceeds queue depth")
  `TFTQ_ASSERT(a_attempts_bound, (attempts_spent != 4'hF), "attempt count ran past any limit")
  `TFTQ_ASSERT_NEXT(a_word_starts, in_fire, (state != tftq_pkg::S_IDLE), "accepted word did not start")
  `TFTQ_ASSERT(a_head_matches_fill, (!out_valid || (out_data.head_valid == (out_data.queue_fill != 4'd0))), "head valid disagrees with fill")

endmodule
